FILE: hdl/shell_quote_escaper_defines.svh
// ----------------------------------------------------------------------------
// shell_quote_escaper assertion macros
// shared property forms for the quoting block checks
// ----------------------------------------------------------------------------
`ifndef SHELL_QUOTE_ESCAPER_DEFINES_SVH
`define SHELL_QUOTE_ESCAPER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SQE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SQE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sqe_pkg.sv
// ----------------------------------------------------------------------------
// sqe_pkg
// types and character constants for the shell quoting block
// ----------------------------------------------------------------------------
`default_nettype none

package sqe_pkg;

  localparam int RUN_MAX = 9;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [RUN_MAX-1:0][7:0] run_bytes_t;

  typedef enum logic [1:0] {
    STYLE_RAW    = 2'd0,
    STYLE_DQUOTE = 2'd1,
    STYLE_SHELL  = 2'd2
  } quote_style_t;

  typedef enum logic {
    REG_QUOTE_STYLE  = 1'b0,
    REG_PAD_WHEN_RAW = 1'b1
  } reg_index_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       empty;
  } item_t;

  typedef struct packed {
    run_bytes_t bytes;
    cnt_t       count;
    logic       ends;
  } run_t;

  typedef struct packed {
    logic single_q;
    logic ansi_q;
  } quote_state_t;

  // letter for the named control escapes, zero when octal is needed
  function automatic logic [7:0] ctrl_letter(input logic [7:0] c);
    logic [7:0] l;
    case (c)
      8'h07:   l = 8'h61;
      8'h08:   l = 8'h62;
      8'h09:   l = 8'h74;
      8'h0A:   l = 8'h6E;
      8'h0B:   l = 8'h76;
      8'h0C:   l = 8'h66;
      8'h0D:   l = 8'h72;
      default: l = 8'h00;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sqe_in_reg.sv
// ----------------------------------------------------------------------------
// sqe_in_reg
// input register stage holding one request until the expander takes it
// ----------------------------------------------------------------------------
`default_nettype none

module sqe_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sqe_pkg::item_t item_in,
  input  wire logic          load,
  output logic               pending,
  output sqe_pkg::item_t     item_held
);
  import sqe_pkg::*;

  item_t held;
  logic  held_valid;

  assign in_ready  = !held_valid || load;
  assign pending   = held_valid;
  assign item_held = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (load) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= item_in;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sqe_expand.sv
// ----------------------------------------------------------------------------
// sqe_expand
// expands one string byte into its quoted output run, tracks quote state
// ----------------------------------------------------------------------------
`default_nettype none

module sqe_expand (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sqe_pkg::item_t   item,
  input  wire logic             load,
  input  wire logic [1:0]       quote_style,
  input  wire logic             pad_when_raw,
  output sqe_pkg::run_t         run,
  output sqe_pkg::quote_state_t qstate
);
  import sqe_pkg::*;

  logic       single_q;
  logic       ansi_q;
  logic       single_q_next;
  logic       ansi_q_next;
  run_bytes_t rb;
  cnt_t       n;
  logic       printable;
  logic [7:0] letter;
  logic       is_raw;
  logic       is_dq;

  function automatic void put(inout run_bytes_t b, inout cnt_t k, input logic [7:0] v);
    b[k] = v;
    k = k + cnt_t'(1);
  endfunction

  assign is_raw    = (quote_style == STYLE_RAW);
  assign is_dq     = (quote_style == STYLE_DQUOTE);
  assign printable = (item.data >= CH_PRINT_LO) && (item.data <= CH_PRINT_HI);
  assign letter    = ctrl_letter(item.data);

  always_comb begin
    rb            = '0;
    n             = '0;
    single_q_next = single_q;
    ansi_q_next   = ansi_q;
    if (item.empty) begin
      if (is_raw) begin
        if (pad_when_raw) put(rb, n, CH_SPACE);
      end else if (is_dq) begin
        put(rb, n, CH_DQUOTE);
        put(rb, n, CH_DQUOTE);
      end else begin
        put(rb, n, CH_APOS);
        put(rb, n, CH_APOS);
      end
      single_q_next = 1'b0;
      ansi_q_next   = 1'b0;
    end else begin
      if (item.first) begin
        if (is_raw) begin
          if (pad_when_raw) put(rb, n, CH_SPACE);
        end else if (is_dq) begin
          put(rb, n, CH_DQUOTE);
        end else begin
          put(rb, n, CH_APOS);
          single_q_next = 1'b1;
          ansi_q_next   = 1'b0;
        end
      end
      if (is_raw || is_dq) begin
        put(rb, n, item.data);
      end else if (printable && item.data != CH_APOS) begin
        if (ansi_q_next) begin
          put(rb, n, CH_APOS);
          ansi_q_next = 1'b0;
        end
        if (!single_q_next) begin
          put(rb, n, CH_APOS);
          single_q_next = 1'b1;
        end
        put(rb, n, item.data);
      end else if (item.data == CH_APOS) begin
        if (ansi_q_next) begin
          put(rb, n, CH_APOS);
          ansi_q_next = 1'b0;
        end
        if (single_q_next) begin
          put(rb, n, CH_APOS);
          put(rb, n, CH_BSLASH);
          put(rb, n, CH_APOS);
          put(rb, n, CH_APOS);
        end else begin
          put(rb, n, CH_BSLASH);
          put(rb, n, CH_APOS);
        end
      end else begin
        if (single_q_next) begin
          put(rb, n, CH_APOS);
          single_q_next = 1'b0;
        end
        if (!ansi_q_next) begin
          put(rb, n, CH_DOLLAR);
          put(rb, n, CH_APOS);
          ansi_q_next = 1'b1;
        end
        put(rb, n, CH_BSLASH);
        if (letter != 8'h00) begin
          put(rb, n, letter);
        end else begin
          put(rb, n, CH_ZERO + {6'd0, item.data[7:6]});
          put(rb, n, CH_ZERO + {5'd0, item.data[5:3]});
          put(rb, n, CH_ZERO + {5'd0, item.data[2:0]});
        end
      end
      if (item.last) begin
        if (is_dq) begin
          put(rb, n, CH_DQUOTE);
        end else if (!is_raw && (single_q_next || ansi_q_next)) begin
          put(rb, n, CH_APOS);
        end
        single_q_next = 1'b0;
        ansi_q_next   = 1'b0;
      end
    end
  end

  assign run.bytes = rb;
  assign run.count = n;
  assign run.ends  = item.last || item.empty;

  assign qstate.single_q = single_q;
  assign qstate.ansi_q   = ansi_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_q <= 1'b0;
      ansi_q   <= 1'b0;
    end else if (load) begin
      single_q <= single_q_next;
      ansi_q   <= ansi_q_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sqe_drain.sv
// ----------------------------------------------------------------------------
// sqe_drain
// run buffer that hands out the expanded bytes one per cycle while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module sqe_drain (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pending,
  input  wire sqe_pkg::run_t run,
  output logic               load,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               last_of_run,
  output logic               end_of_string
);
  import sqe_pkg::*;

  run_t buf_run;
  logic buf_valid;
  cnt_t idx;
  logic at_last;
  logic free;

  assign at_last = (idx == buf_run.count - cnt_t'(1));
  assign free    = !buf_valid || (out_ready && at_last);
  assign load    = pending && free;

  assign out_valid     = buf_valid;
  assign out_byte      = buf_run.bytes[idx];
  assign last_of_run   = at_last;
  assign end_of_string = at_last && buf_run.ends;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      buf_valid <= (run.count != '0);
      idx       <= '0;
    end else if (buf_valid && out_ready) begin
      if (at_last) begin
        buf_valid <= 1'b0;
      end
      idx <= idx + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_run <= run;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/shell_quote_escaper.sv
// ----------------------------------------------------------------------------
// shell_quote_escaper
// streams a byte string out in raw, double-quoted or shell-escaped form
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | data_byte, first_byte, last_byte, empty_string
//  out      | out_valid / out_ready| out_byte, last_of_run, end_of_string
//  cfg      | cfg_write            | cfg_index, cfg_data
//
//  one output byte per cycle while out_ready is high, from the single-byte output port
//  of the run buffer; a request expands to up to nine bytes
//  a request's first byte is presented after the input register and run buffer
//  a request that expands to nothing gives no output
//  stalls on out hold the run buffer and back-pressure the input register
//  rst (synchronous) clears the quote state and config to style 2, no padding
// ----------------------------------------------------------------------------
`default_nettype none

`include "shell_quote_escaper_defines.svh"

module shell_quote_escaper (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [1:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  input  wire logic       empty_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            end_of_string
);
  import sqe_pkg::*;

  logic [1:0]   quote_style;
  logic         pad_when_raw;
  item_t        item_in;
  item_t        item_held;
  logic         pending;
  logic         load;
  run_t         run;
  quote_state_t qstate;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_style  <= STYLE_SHELL;
      pad_when_raw <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_QUOTE_STYLE:  quote_style  <= cfg_data;
        REG_PAD_WHEN_RAW: pad_when_raw <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item_in.data  = data_byte;
  assign item_in.first = first_byte;
  assign item_in.last  = last_byte;
  assign item_in.empty = empty_string;

  sqe_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item_in   (item_in),
    .load      (load),
    .pending   (pending),
    .item_held (item_held)
  );

  sqe_expand u_expand (
    .clk          (clk),
    .rst          (rst),
    .item         (item_held),
    .load         (load),
    .quote_style  (quote_style),
    .pad_when_raw (pad_when_raw),
    .run          (run),
    .qstate       (qstate)
  );

  sqe_drain u_drain (
    .clk           (clk),
    .rst           (rst),
    .pending       (pending),
    .run           (run),
    .load          (load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .end_of_string (end_of_string)
  );

  `SQE_ASSERT_IMPLY(a_quote_excl, clk, rst, 1'b1, !(qstate.single_q && qstate.ansi_q), "both quote sections open")
  `SQE_ASSERT_IMPLY(a_eos_on_last, clk, rst, out_valid && end_of_string, last_of_run, "end of string before end of run")
  `SQE_ASSERT_NEXT(a_run_continues, clk, rst, out_valid && out_ready && !last_of_run, out_valid, "run dropped before its last byte")
  `SQE_ASSERT_IMPLY(a_load_held, clk, rst, load, pending, "expander loaded with no request held")

endmodule

`default_nettype wire
